[rtl/core/srgb_pkg.sv]
// Shared types and constants of the serial RGB LED driver.
// Holds transaction payload structs, configuration struct, operation and phase codes.
// No dependencies.
`timescale 1ns / 1ps

package srgb_pkg;

	localparam int BYTES_PER_LED = 3;
	localparam int ROW_W         = BYTES_PER_LED * 8;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;

	// operation codes of a command transaction
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LATCH_GAP  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 3'd5;

	// configuration reset values
	localparam logic [6:0]  RST_LED_COUNT  = 7'd10;
	localparam logic [7:0]  RST_ONE_HIGH   = 8'd13;
	localparam logic [7:0]  RST_ZERO_HIGH  = 8'd5;
	localparam logic [7:0]  RST_BIT_PERIOD = 8'd20;
	localparam logic [15:0] RST_LATCH_GAP  = 16'd800;
	localparam logic        RST_INVERT     = 1'b0;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SEND,
		PH_GAP
	} phase_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [5:0] led_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} cmd_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_done;
	} res_t;

	typedef struct packed {
		logic [6:0]  led_count;
		logic [7:0]  one_high_ticks;
		logic [7:0]  zero_high_ticks;
		logic [7:0]  bit_period_ticks;
		logic [15:0] latch_gap_ticks;
		logic        invert_line;
	} cfg_t;

endpackage

[rtl/core/srgb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module srgb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic [AW-1:0]         raddr,
	output logic [WIDTH-1:0]      rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/srgb_store.sv]
// Colour frame store: one row of green, red, blue per LED.
// Row valid bits make unwritten rows read as zero; a registered bypass covers
// a write to the row being read. Uses srgb_pkg and srgb_ram.
`timescale 1ns / 1ps

module srgb_store #(
	parameter int MAX_LEDS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [srgb_pkg::ROW_W-1:0] wr_data,
	input  logic [AW-1:0]              rd_addr,
	output logic [srgb_pkg::ROW_W-1:0] rdata
);

	localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

	logic [MAX_LEDS-1:0]        row_valid_q;
	logic                       rvalid_q;
	logic                       fwd_hit_q;
	logic [srgb_pkg::ROW_W-1:0] fwd_data_q;
	logic [srgb_pkg::ROW_W-1:0] ram_rdata;

	srgb_ram #(
		.WIDTH(srgb_pkg::ROW_W),
		.DEPTH(MAX_LEDS)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvalid_q    <= 1'b0;
			fwd_hit_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			rvalid_q  <= row_valid_q[rd_addr];
			fwd_hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= wr_data;
	end

	// the RAM returns old data on a same-cycle write, so take the bypass
	assign rdata = fwd_hit_q ? fwd_data_q : (rvalid_q ? ram_rdata : '0);

endmodule

[rtl/core/srgb_cfg.sv]
// Configuration register file of the LED driver.
// Depends on srgb_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module srgb_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [srgb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srgb_pkg::CFG_DATA_W-1:0] cfg_data,
	output srgb_pkg::cfg_t                  cfg
);

	srgb_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.led_count        <= srgb_pkg::RST_LED_COUNT;
			cfg_q.one_high_ticks   <= srgb_pkg::RST_ONE_HIGH;
			cfg_q.zero_high_ticks  <= srgb_pkg::RST_ZERO_HIGH;
			cfg_q.bit_period_ticks <= srgb_pkg::RST_BIT_PERIOD;
			cfg_q.latch_gap_ticks  <= srgb_pkg::RST_LATCH_GAP;
			cfg_q.invert_line      <= srgb_pkg::RST_INVERT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				srgb_pkg::REG_LED_COUNT:  cfg_q.led_count        <= cfg_data[6:0];
				srgb_pkg::REG_ONE_HIGH:   cfg_q.one_high_ticks   <= cfg_data[7:0];
				srgb_pkg::REG_ZERO_HIGH:  cfg_q.zero_high_ticks  <= cfg_data[7:0];
				srgb_pkg::REG_BIT_PERIOD: cfg_q.bit_period_ticks <= cfg_data[7:0];
				srgb_pkg::REG_LATCH_GAP:  cfg_q.latch_gap_ticks  <= cfg_data;
				srgb_pkg::REG_INVERT:     cfg_q.invert_line      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/srgb_engine.sv]
// Frame sequencer and line waveform of the LED driver: phase, bit cell counters,
// current LED row, and the result of each command. Depends on srgb_pkg.
`timescale 1ns / 1ps

module srgb_engine #(
	parameter int MAX_LEDS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  srgb_pkg::cmd_t             cmd,
	input  srgb_pkg::cfg_t             cfg,
	input  logic [srgb_pkg::ROW_W-1:0] rdata,
	output logic [AW-1:0]              rd_addr,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [srgb_pkg::ROW_W-1:0] wr_data,
	output srgb_pkg::res_t             res
);

	localparam int AW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int CNT_W = ($clog2(MAX_LEDS + 1) > 7) ? $clog2(MAX_LEDS + 1) : 7;

	srgb_pkg::phase_t           phase_q, phase_d;
	logic [AW-1:0]              led_row_q, led_row_d;
	logic [1:0]                 byte_sel_q, byte_sel_d;
	logic [2:0]                 bit_pos_q, bit_pos_d;
	logic [7:0]                 cell_q, cell_d;
	logic [15:0]                gap_q, gap_d;
	logic [srgb_pkg::ROW_W-1:0] cur_row_q, cur_row_d;

	logic [CNT_W-1:0] eff_leds;
	logic [7:0]       period;
	logic [15:0]      gap_len;
	logic             is_write, is_start, is_tick;
	logic             start_go;
	logic [4:0]       bit_idx;
	logic             cur_bit;
	logic [7:0]       high_ticks;
	logic [7:0]       start_high;
	logic             active;
	logic [8:0]       cell_inc;
	logic             cell_end;
	logic [16:0]      gap_inc;
	logic             gap_end;
	logic             last_row;
	logic             level_raw;

	// LED count saturates at the store depth
	assign eff_leds = (CNT_W'(cfg.led_count) > CNT_W'(MAX_LEDS))
		? CNT_W'(MAX_LEDS) : CNT_W'(cfg.led_count);
	assign period   = (cfg.bit_period_ticks == 8'd0) ? 8'd1 : cfg.bit_period_ticks;
	assign gap_len  = (cfg.latch_gap_ticks == 16'd0) ? 16'd1 : cfg.latch_gap_ticks;

	always_comb begin
		is_write = 1'b0;
		is_start = 1'b0;
		is_tick  = 1'b0;
		unique case (cmd.operation)
			srgb_pkg::OP_WRITE: is_write = 1'b1;
			srgb_pkg::OP_START: is_start = 1'b1;
			srgb_pkg::OP_TICK:  is_tick  = 1'b1;
			default: ;
		endcase
	end

	assign start_go = fire && is_start && (phase_q == srgb_pkg::PH_IDLE);

	assign wr_en   = fire && is_write && (phase_q == srgb_pkg::PH_IDLE)
		&& (CNT_W'(cmd.led_index) < eff_leds);
	assign wr_addr = AW'(cmd.led_index);
	assign wr_data = {cmd.green, cmd.red, cmd.blue};

	// prefetch the next row while sending, row 0 otherwise
	assign rd_addr = (phase_q == srgb_pkg::PH_SEND) ? (led_row_q + AW'(1)) : '0;

	// bits leave MSB first, green byte first
	assign bit_idx    = {byte_sel_q, bit_pos_q};
	assign cur_bit    = cur_row_q[5'd23 - bit_idx];
	assign high_ticks = cur_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;
	assign active     = (phase_q == srgb_pkg::PH_SEND) && (cell_q < high_ticks);
	assign start_high = rdata[srgb_pkg::ROW_W-1] ? cfg.one_high_ticks
		: cfg.zero_high_ticks;

	assign cell_inc = {1'b0, cell_q} + 9'd1;
	assign cell_end = cell_inc >= {1'b0, period};
	assign gap_inc  = {1'b0, gap_q} + 17'd1;
	assign gap_end  = gap_inc >= {1'b0, gap_len};
	assign last_row = (CNT_W'(led_row_q) + CNT_W'(1)) >= eff_leds;

	// next state
	always_comb begin
		phase_d    = phase_q;
		led_row_d  = led_row_q;
		byte_sel_d = byte_sel_q;
		bit_pos_d  = bit_pos_q;
		cell_d     = cell_q;
		gap_d      = gap_q;
		cur_row_d  = cur_row_q;
		unique case (phase_q)
			srgb_pkg::PH_IDLE: begin
				if (start_go) begin
					led_row_d  = '0;
					byte_sel_d = 2'd0;
					bit_pos_d  = 3'd0;
					cell_d     = 8'd0;
					gap_d      = 16'd0;
					cur_row_d  = rdata;
					phase_d    = (eff_leds == '0) ? srgb_pkg::PH_GAP : srgb_pkg::PH_SEND;
				end
			end
			srgb_pkg::PH_SEND: begin
				if (fire && is_tick) begin
					if (cell_end) begin
						cell_d    = 8'd0;
						bit_pos_d = bit_pos_q + 3'd1;
						if (bit_pos_q == 3'd7) begin
							if (byte_sel_q == 2'd2) begin
								byte_sel_d = 2'd0;
								if (last_row) begin
									phase_d = srgb_pkg::PH_GAP;
									gap_d   = 16'd0;
								end else begin
									led_row_d = led_row_q + AW'(1);
									cur_row_d = rdata;
								end
							end else begin
								byte_sel_d = byte_sel_q + 2'd1;
							end
						end
					end else begin
						cell_d = cell_inc[7:0];
					end
				end
			end
			srgb_pkg::PH_GAP: begin
				if (fire && is_tick) begin
					if (gap_end) begin
						gap_d   = 16'd0;
						phase_d = srgb_pkg::PH_IDLE;
					end else begin
						gap_d = gap_inc[15:0];
					end
				end
			end
			default: phase_d = srgb_pkg::PH_IDLE;
		endcase
	end

	// result of the current command
	always_comb begin
		if (start_go) begin
			level_raw = (eff_leds != '0) && (start_high != 8'd0);
		end else begin
			level_raw = active;
		end
		res.line_level = level_raw ^ cfg.invert_line;
		res.busy_res   = (phase_d != srgb_pkg::PH_IDLE);
		res.frame_done = fire && is_tick && (phase_q == srgb_pkg::PH_GAP) && gap_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= srgb_pkg::PH_IDLE;
			led_row_q  <= '0;
			byte_sel_q <= 2'd0;
			bit_pos_q  <= 3'd0;
			cell_q     <= 8'd0;
			gap_q      <= 16'd0;
		end else begin
			phase_q    <= phase_d;
			led_row_q  <= led_row_d;
			byte_sel_q <= byte_sel_d;
			bit_pos_q  <= bit_pos_d;
			cell_q     <= cell_d;
			gap_q      <= gap_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_row_q <= cur_row_d;
	end

`ifndef NO_ASSERTIONS
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.frame_done |-> !res.busy_res)
		else $error("frame_done reported while still busy");

	a_counters_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != srgb_pkg::PH_SEND) |-> (cell_q == 8'd0 && bit_pos_q == 3'd0
			&& byte_sel_q == 2'd0))
		else $error("bit cell counters not cleared outside a frame");

	a_gap_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.frame_done |=> (phase_q == srgb_pkg::PH_IDLE))
		else $error("latch gap ended without returning to idle");

	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start_go |=> (phase_q != srgb_pkg::PH_IDLE))
		else $error("frame start did not leave idle");
`endif

endmodule

[rtl/core/serial_rgb_led_driver.sv]
// Top level of the serial RGB LED driver: command and result registers around
// the sequencer, frame store and configuration registers. Uses srgb_pkg,
// srgb_cfg, srgb_store and srgb_engine.
//
//   channel | handshake          | payload
//   --------+--------------------+----------------------------------------
//   cmd     | cmd_valid/cmd_stall| cmd_t: operation, led_index, red, green, blue
//   res     | res_valid/res_stall| res_t: line_level, busy_res, frame_done
//   cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data (register write)
//
// One command per clock while results are not stalled: each is registered on
// accept, processed once the result register has room, and its result lands there.
// Reset loads register defaults; the frame store reads as zero through per-row
// valid bits, so no clearing pass is needed. A stalled result holds; a new
// command is still taken while the input register is free.
// The store is read one row ahead, so every tick sees its bit without waiting.
`timescale 1ns / 1ps

module serial_rgb_led_driver #(
	parameter int MAX_LEDS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_stall,
	input  srgb_pkg::cmd_t                  cmd,
	output logic                            res_valid,
	input  logic                            res_stall,
	output srgb_pkg::res_t                  res,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [srgb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srgb_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

	srgb_pkg::cmd_t             cmd_s1;
	logic                       valid_s1;
	srgb_pkg::res_t             res_s2;
	logic                       res_valid_s2;
	logic                       fire;
	logic                       accept;
	srgb_pkg::cfg_t             cfg;
	srgb_pkg::res_t             res_d;
	logic [AW-1:0]              rd_addr;
	logic [AW-1:0]              wr_addr;
	logic                       wr_en;
	logic [srgb_pkg::ROW_W-1:0] wr_data;
	logic [srgb_pkg::ROW_W-1:0] rdata;

	// process the held command once the result register has room
	assign fire      = valid_s1 && (!res_valid_s2 || !res_stall);
	assign cmd_stall = valid_s1 && !fire;
	assign accept    = cmd_valid && !cmd_stall;

	srgb_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	srgb_store #(
		.MAX_LEDS(MAX_LEDS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rdata  (rdata)
	);

	srgb_engine #(
		.MAX_LEDS(MAX_LEDS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.cmd    (cmd_s1),
		.cfg    (cfg),
		.rdata  (rdata),
		.rd_addr(rd_addr),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !fire);
			if (fire) begin
				res_valid_s2 <= 1'b1;
			end else if (!res_stall) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
		if (fire) begin
			res_s2 <= res_d;
		end
	end

	assign res_valid = res_valid_s2;
	assign res       = res_s2;

`ifndef NO_ASSERTIONS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (res_valid_s2 && res_stall))
		else $error("command stalled while the result register had room");

	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> res_valid)
		else $error("processed command produced no result transaction");

	a_held_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fire) |=> (valid_s1 && $stable(cmd_s1)))
		else $error("held command lost before processing");
`endif

endmodule

[test/srgb_line_checker.sv]
// Checker for the serial RGB LED driver: predicts each result from the accepted commands
// and configuration writes and compares it with what the driver returns.
// Depends on srgb_pkg.
`timescale 1ns / 1ps

module srgb_line_checker import srgb_pkg::*; #(
	parameter int MAX_LEDS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  logic                  cmd_stall,
	input  cmd_t                  cmd,
	input  logic                  res_valid,
	input  logic                  res_stall,
	input  res_t                  res,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    outstanding
);

	localparam int STORE_BYTES = MAX_LEDS * BYTES_PER_LED;

	cfg_t       setting;
	logic [7:0] colour_mem [STORE_BYTES];
	logic [7:0] byte_pos;
	logic [2:0] bit_pos;
	logic [7:0] cell_cnt;
	logic [15:0] gap_cnt;
	phase_t     phase;
	res_t       expected_levels [$];
	res_t       want;

	function automatic logic [6:0] strip_leds();
		return (setting.led_count > MAX_LEDS) ? 7'(MAX_LEDS) : setting.led_count;
	endfunction

	// unpolarized level that the current bit cell drives
	function automatic logic drive_active();
		logic [7:0] colour;
		logic [7:0] high;
		if (phase != PH_SEND)
			return 1'b0;
		colour = colour_mem[byte_pos];
		high = colour[3'd7 - bit_pos] ? setting.one_high_ticks : setting.zero_high_ticks;
		return cell_cnt < high;
	endfunction

	function automatic res_t next_line_state(input cmd_t c);
		res_t        r;
		logic        lvl;
		logic        done;
		int          base;
		logic [7:0]  period;
		logic [15:0] gap;
		lvl = 1'b0;
		done = 1'b0;
		period = (setting.bit_period_ticks == 8'd0) ? 8'd1 : setting.bit_period_ticks;
		gap = (setting.latch_gap_ticks == 16'd0) ? 16'd1 : setting.latch_gap_ticks;
		case (c.operation)
			OP_WRITE: begin
				if (phase == PH_IDLE && c.led_index < strip_leds()) begin
					base = c.led_index * BYTES_PER_LED;
					colour_mem[base] = c.green;
					colour_mem[base + 1] = c.red;
					colour_mem[base + 2] = c.blue;
				end
			end
			OP_START: begin
				if (phase == PH_IDLE) begin
					byte_pos = 8'd0;
					bit_pos = 3'd0;
					cell_cnt = 8'd0;
					gap_cnt = 16'd0;
					phase = (strip_leds() == 7'd0) ? PH_GAP : PH_SEND;
				end
			end
			OP_TICK: begin
				// a tick reports the level it drove, then advances
				lvl = drive_active();
				if (phase == PH_SEND) begin
					cell_cnt++;
					if (cell_cnt >= period) begin
						cell_cnt = 8'd0;
						bit_pos++;
						if (bit_pos == 3'd0) begin
							byte_pos++;
							if (byte_pos >= strip_leds() * BYTES_PER_LED) begin
								phase = PH_GAP;
								gap_cnt = 16'd0;
							end
						end
					end
				end else if (phase == PH_GAP) begin
					gap_cnt++;
					if (gap_cnt >= gap) begin
						gap_cnt = 16'd0;
						phase = PH_IDLE;
						done = 1'b1;
					end
				end
			end
			default: ;
		endcase
		if (c.operation != OP_TICK)
			lvl = drive_active();
		r.line_level = lvl ^ setting.invert_line;
		r.busy_res = (phase != PH_IDLE);
		r.frame_done = done;
		return r;
	endfunction

	function automatic void flag(input string field, input logic exp_bit, input logic got_bit);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t ns: %s expected %0b got %0b", $time, field, exp_bit, got_bit);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setting = '{RST_LED_COUNT, RST_ONE_HIGH, RST_ZERO_HIGH, RST_BIT_PERIOD,
				RST_LATCH_GAP, RST_INVERT};
			foreach (colour_mem[i])
				colour_mem[i] = 8'h00;
			byte_pos = 8'd0;
			bit_pos = 3'd0;
			cell_cnt = 8'd0;
			gap_cnt = 16'd0;
			phase = PH_IDLE;
			expected_levels.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_levels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t ns: result %p arrived with nothing pending", $time, res);
				end else begin
					want = expected_levels.pop_front();
					if (res.line_level !== want.line_level)
						flag("line_level", want.line_level, res.line_level);
					if (res.busy_res !== want.busy_res)
						flag("busy_res", want.busy_res, res.busy_res);
					if (res.frame_done !== want.frame_done)
						flag("frame_done", want.frame_done, res.frame_done);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LED_COUNT:  setting.led_count = cfg_data[6:0];
					REG_ONE_HIGH:   setting.one_high_ticks = cfg_data[7:0];
					REG_ZERO_HIGH:  setting.zero_high_ticks = cfg_data[7:0];
					REG_BIT_PERIOD: setting.bit_period_ticks = cfg_data[7:0];
					REG_LATCH_GAP:  setting.latch_gap_ticks = cfg_data;
					REG_INVERT:     setting.invert_line = cfg_data[0];
					default: ;
				endcase
			end
			if (cmd_valid && !cmd_stall)
				expected_levels.push_back(next_line_state(cmd));
			outstanding = expected_levels.size();
		end
	end

endmodule

[test/serial_rgb_led_driver_tb.sv]
// Testbench top for the serial RGB LED driver: clock, reset, command and configuration
// stimulus, result back-pressure and the final verdict.
// Depends on srgb_pkg, serial_rgb_led_driver and srgb_line_checker.
`timescale 1ns / 1ps

module serial_rgb_led_driver_tb;
	import srgb_pkg::*;

	localparam int MAX_LEDS = 64;
	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_ITEMS = 1750;
	localparam logic [1:0] OP_SPARE = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cmd_valid = 1'b0;
	logic                  cmd_stall;
	cmd_t                  cmd = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	res_t                  res;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int          mismatches;
	int          outstanding;
	logic        quiet = 1'b0;
	logic        hold_req = 1'b0;
	cfg_t        cur_cfg;
	cfg_t        trial;
	int unsigned frame_left;
	int unsigned items_sent;
	int unsigned random_from;

	serial_rgb_led_driver #(.MAX_LEDS(MAX_LEDS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	srgb_line_checker #(.MAX_LEDS(MAX_LEDS)) line_chk (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("serial_rgb_led_driver: mismatch");
		$finish;
	end

	// mostly short idle runs, now and then a long one
	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	// ticks from a start until the driver is idle again
	function automatic int unsigned frame_ticks();
		int unsigned leds;
		int unsigned period;
		int unsigned gap;
		leds = (cur_cfg.led_count > MAX_LEDS) ? MAX_LEDS : cur_cfg.led_count;
		period = (cur_cfg.bit_period_ticks == 8'd0) ? 1 : cur_cfg.bit_period_ticks;
		gap = (cur_cfg.latch_gap_ticks == 16'd0) ? 1 : cur_cfg.latch_gap_ticks;
		return leds * BYTES_PER_LED * 8 * period + gap;
	endfunction

	// result back-pressure
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				res_stall = 1'b0;
				hold_req = 1'b0;
			end else if (quiet) begin
				res_stall = 1'b0;
			end else begin
				res_stall = ($urandom_range(0, 3) == 0);
				if (res_stall)
					repeat (gap_len() - 1) @(negedge clk);
			end
		end
	end

	task automatic push_cmd(input logic [1:0] op, input logic [5:0] idx, input logic [23:0] rgb);
		int gap;
		gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : gap_len();
		if (gap > 0) begin
			cmd_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd = '{operation: op, led_index: idx, red: rgb[23:16], green: rgb[15:8],
			blue: rgb[7:0]};
		cmd_valid = 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		if (op == OP_START && frame_left == 0)
			frame_left = frame_ticks();
		else if (op == OP_TICK && frame_left != 0)
			frame_left--;
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// reprogram only once every result is back and the pipeline has drained
	task automatic set_config(input cfg_t c);
		cmd_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		write_reg(REG_LED_COUNT, CFG_DATA_W'(c.led_count));
		write_reg(REG_ONE_HIGH, CFG_DATA_W'(c.one_high_ticks));
		write_reg(REG_ZERO_HIGH, CFG_DATA_W'(c.zero_high_ticks));
		write_reg(REG_BIT_PERIOD, CFG_DATA_W'(c.bit_period_ticks));
		write_reg(REG_LATCH_GAP, c.latch_gap_ticks);
		write_reg(REG_INVERT, CFG_DATA_W'(c.invert_line));
		cur_cfg = c;
	endtask

	// load colours, start a frame and tick it out to idle, with stray commands mixed in
	task automatic run_frame(input int noise_pct);
		int unsigned leds;
		int          n;
		leds = (cur_cfg.led_count > MAX_LEDS) ? MAX_LEDS : cur_cfg.led_count;
		n = $urandom_range(0, leds + 2);
		repeat (n) begin
			if ($urandom_range(0, 99) < 85)
				push_cmd(OP_WRITE, (leds == 0 || $urandom_range(0, 4) == 0) ?
					6'($urandom()) : 6'($urandom_range(0, leds - 1)), 24'($urandom()));
			else
				push_cmd($urandom_range(0, 1) ? OP_TICK : OP_SPARE, 6'($urandom()),
					24'($urandom()));
		end
		push_cmd(OP_START, 6'($urandom()), 24'($urandom()));
		while (frame_left != 0) begin
			if ($urandom_range(0, 99) < noise_pct)
				push_cmd(2'($urandom()), 6'($urandom()), 24'($urandom()));
			else
				push_cmd(OP_TICK, 6'($urandom()), 24'($urandom()));
		end
	endtask

	initial begin
		cur_cfg = '{RST_LED_COUNT, RST_ONE_HIGH, RST_ZERO_HIGH, RST_BIT_PERIOD,
			RST_LATCH_GAP, RST_INVERT};
		frame_left = 0;
		items_sent = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: idle ticks, spare code, range edges of the index, busy drops
		push_cmd(OP_TICK, 6'd0, 24'h000000);
		push_cmd(OP_SPARE, 6'h3F, 24'hFFFFFF);
		push_cmd(OP_WRITE, 6'd0, 24'hFF00FF);
		push_cmd(OP_WRITE, 6'd9, 24'h00FF80);
		push_cmd(OP_WRITE, 6'd10, 24'h123456);
		push_cmd(OP_WRITE, 6'd63, 24'hFFFFFF);
		push_cmd(OP_WRITE, 6'd5, 24'hFFFFFF);
		push_cmd(OP_WRITE, 6'd2, 24'h5AA501);
		push_cmd(OP_START, 6'd0, 24'h000000);
		repeat (3) push_cmd(OP_TICK, 6'd0, 24'h000000);
		push_cmd(OP_WRITE, 6'd1, 24'hABCDEF);
		push_cmd(OP_START, 6'd0, 24'h000000);
		push_cmd(OP_SPARE, 6'd0, 24'h000000);
		// back up the result side while ticks keep coming
		quiet = 1'b1;
		hold_req = 1'b1;
		while (frame_left != 0)
			push_cmd(OP_TICK, 6'($urandom()), 24'($urandom()));

		// edge settings, run without idling since the frames are long
		set_config('{7'd1, 8'd255, 8'd0, 8'd255, 16'd1, 1'b1});
		run_frame(5);
		set_config('{7'd0, 8'd1, 8'd1, 8'd1, 16'd0, 1'b0});
		run_frame(20);
		set_config('{7'd127, 8'd0, 8'd255, 8'd0, 16'd3, 1'b1});
		run_frame(5);
		set_config('{7'd1, 8'd1, 8'd0, 8'd2, 16'hFFFF, 1'b0});
		run_frame(1);
		quiet = 1'b0;

		random_from = items_sent;
		while (items_sent - random_from < RANDOM_ITEMS) begin
			trial.bit_period_ticks = 8'($urandom_range(0, 6));
			trial.one_high_ticks = ($urandom_range(0, 7) == 0) ? 8'($urandom()) :
				8'($urandom_range(0, trial.bit_period_ticks + 1));
			trial.zero_high_ticks = ($urandom_range(0, 7) == 0) ? 8'($urandom()) :
				8'($urandom_range(0, trial.bit_period_ticks + 1));
			trial.led_count = ($urandom_range(0, 7) == 0) ? 7'd0 : 7'($urandom_range(1, 3));
			trial.latch_gap_ticks = 16'($urandom_range(0, 12));
			trial.invert_line = 1'($urandom());
			set_config(trial);
			quiet = ($urandom_range(0, 3) == 0);
			run_frame($urandom_range(0, 30));
		end
		quiet = 1'b0;

		cmd_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("serial_rgb_led_driver: match");
		else
			$display("serial_rgb_led_driver: mismatch");
		$finish;
	end

endmodule
